// ===== rtl/core/greedy_weighted_graph_walk_core_defines.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the graph walk core
// ----------------------------------------------------------------------------
`ifndef GREEDY_WEIGHTED_GRAPH_WALK_CORE_DEFINES_SVH
`define GREEDY_WEIGHTED_GRAPH_WALK_CORE_DEFINES_SVH
// implication checked on every clock outside reset
`define GWW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define GWW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/gww_pkg.sv =====
// ----------------------------------------------------------------------------
// gww_pkg
// types, constants and codes shared by the graph walk core
// ----------------------------------------------------------------------------
package gww_pkg;
    localparam int CONCEPT_SLOTS = 64;
    localparam int EDGE_SLOTS    = 64;
    localparam int DEPTH_LIMIT   = 8;
    localparam int CA_W  = $clog2(CONCEPT_SLOTS);
    localparam int EA_W  = $clog2(EDGE_SLOTS);
    localparam int CC_W  = $clog2(CONCEPT_SLOTS + 1);
    localparam int EC_W  = $clog2(EDGE_SLOTS + 1);
    localparam int VD_W  = $clog2(DEPTH_LIMIT);
    localparam int ID_W  = 32;
    localparam int WT_W  = 17;
    localparam int DEP_W = 4;
    localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [DEP_W-1:0] DEPTH_MAX = DEP_W'(DEPTH_LIMIT);
    localparam logic [DEP_W-1:0] DEPTH_RESET = 4'd4;
    localparam int EDGE_W = 2 * ID_W + WT_W;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0, OP_ADD_CONCEPT = 2'd1, OP_ADD_EDGE = 2'd2, OP_WALK = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_ACK = 2'd0, KIND_NODE = 2'd1, KIND_END = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] concept_id;
        logic [ID_W-1:0] target_id;
        logic [WT_W-1:0] weight;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  node_id;
        logic [WT_W-1:0]  confidence;
        logic [DEP_W-1:0] path_length;
        logic             status;
        logic             last;
    } out_beat_t;
endpackage

// ===== rtl/core/gww_ram.sv =====
// ----------------------------------------------------------------------------
// gww_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module gww_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/greedy_weighted_graph_walk_core.sv =====
// ----------------------------------------------------------------------------
// greedy_weighted_graph_walk_core
// concept and edge tables in ram with a greedy heaviest-edge walk
// ----------------------------------------------------------------------------
//  channel | ports          | payload     | beats per item
//  in      | s_valid/ready  | in_beat_t   | 1
//  out     | m_valid/ready  | out_beat_t  | 1 ack, or up to 9 for a walk
//  cfg     | cfg_we/wdata   | max_depth   | write only
//
// clear passes through ack and emit, add edge through edge write, ack and emit; add
// concept searches the concept ram, then acts on the result, acks and emits
// a walk step searches the concept ram, emits the node, scans the edge ram and
// folds the product in; each search or scan reads one entry at a time, as each
// ram has a single read port
// synchronous reset clears counts and the fsm, sets max_depth to 4; ram contents undefined
// m_ready low stalls the fsm at each emitted beat; s_ready only in idle
module greedy_weighted_graph_walk_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  gww_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gww_pkg::out_beat_t m_data
);
    import gww_pkg::*;
    `include "greedy_weighted_graph_walk_core_defines.svh"

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CSCAN  = 9'b000000010,  // search concept ram
        ST_CDONE  = 9'b000000100,  // act on search result
        ST_ESCAN  = 9'b000001000,  // scan edges of current node
        ST_EDONE  = 9'b000010000,  // fold best edge in
        ST_MUL    = 9'b000100000,  // register the product
        ST_EMIT   = 9'b001000000,  // out beat waits for m_ready
        ST_EWR    = 9'b010000000,  // edge write
        ST_ACK    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    state_t after_reg;                  // state after emit

    logic [DEP_W-1:0] max_depth_reg;
    logic [CC_W-1:0]  ccount_reg;
    logic [EC_W-1:0]  ecount_reg;
    in_beat_t         req_reg;
    logic [ID_W-1:0]  cur_reg;
    logic [WT_W-1:0]  conf_reg;
    logic [DEP_W-1:0] n_reg;
    logic [EC_W-1:0]  idx_reg;          // scan address counter
    logic             rvalid_reg;       // ram data valid this cycle
    logic             hit_reg;
    logic             found_reg;
    logic [WT_W-1:0]  best_w_reg;
    logic [ID_W-1:0]  best_to_reg;
    logic [ID_W-1:0]  visited_reg [DEPTH_LIMIT];
    logic [2*WT_W-1:0] prod_reg;
    out_beat_t        out_reg;

    // ram ports
    logic              c_we, e_we;
    logic [CA_W-1:0]   c_addr;
    logic [EA_W-1:0]   e_addr;
    logic [ID_W-1:0]   c_rdata;
    logic [EDGE_W-1:0] e_wdata, e_rdata;
    logic [WT_W-1:0]   wclamp;

    gww_ram #(.WIDTH(ID_W), .DEPTH(CONCEPT_SLOTS)) u_concept_ram (
        .aclk(aclk), .we(c_we), .addr(c_addr), .wdata(req_reg.concept_id), .rdata(c_rdata)
    );
    gww_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_SLOTS)) u_edge_ram (
        .aclk(aclk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
    );

    logic [DEP_W-1:0] limit;
    assign limit = (max_depth_reg > DEPTH_MAX) ? DEPTH_MAX : max_depth_reg;
    assign wclamp = (req_reg.weight > ONE_Q16) ? ONE_Q16 : req_reg.weight;
    assign e_wdata = {req_reg.concept_id, req_reg.target_id, wclamp};

    // key the concept search compares against
    logic [ID_W-1:0] ckey;
    assign ckey = (req_reg.opcode == OP_ADD_CONCEPT) ? req_reg.concept_id : cur_reg;

    logic [ID_W-1:0] e_src, e_dst;
    logic [WT_W-1:0] e_w;
    assign e_src = e_rdata[EDGE_W-1 -: ID_W];
    assign e_dst = e_rdata[WT_W +: ID_W];
    assign e_w   = e_rdata[WT_W-1:0];

    logic dst_seen;
    always_comb begin
        dst_seen = 1'b0;
        for (int i = 0; i < DEPTH_LIMIT; i++) begin
            if ((DEP_W'(i) < n_reg) && (visited_reg[i] == e_dst)) begin
                dst_seen = 1'b1;
            end
        end
    end

    logic cscan_end, escan_end;
    assign cscan_end = (idx_reg >= EC_W'(ccount_reg)) && !rvalid_reg;
    assign escan_end = (idx_reg >= ecount_reg) && !rvalid_reg;

    assign c_addr = (state_reg == ST_CDONE) ? ccount_reg[CA_W-1:0] : idx_reg[CA_W-1:0];
    assign e_addr = (state_reg == ST_EWR) ? ecount_reg[EA_W-1:0] : idx_reg[EA_W-1:0];
    assign c_we = (state_reg == ST_CDONE) && (req_reg.opcode == OP_ADD_CONCEPT)
                  && !hit_reg && (ccount_reg < CC_W'(CONCEPT_SLOTS));
    assign e_we = (state_reg == ST_EWR) && (ecount_reg < EC_W'(EDGE_SLOTS));

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.opcode)
                        OP_CLEAR:       state_next = ST_ACK;
                        OP_ADD_EDGE:    state_next = ST_EWR;
                        default:        state_next = ST_CSCAN;
                    endcase
                    if (s_data.opcode == OP_WALK && limit == '0) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CSCAN: if (cscan_end || hit_reg) state_next = ST_CDONE;
            ST_CDONE: begin
                if (req_reg.opcode == OP_ADD_CONCEPT) state_next = ST_ACK;
                else state_next = ST_EMIT;
            end
            ST_ESCAN: if (escan_end) state_next = ST_EDONE;
            ST_EDONE: state_next = found_reg ? ST_MUL : ST_EMIT;
            // depth reached: end beat next, else search the chosen node
            ST_MUL:   state_next = (n_reg >= limit) ? ST_EMIT : ST_CSCAN;
            ST_EWR:   state_next = ST_ACK;
            ST_ACK:   state_next = ST_EMIT;
            ST_EMIT:  if (m_ready) state_next = after_reg;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            after_reg     <= ST_IDLE;
            max_depth_reg <= DEPTH_RESET;
            ccount_reg    <= '0;
            ecount_reg    <= '0;
            rvalid_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) max_depth_reg <= cfg_wdata;
            rvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    req_reg    <= s_data;
                    cur_reg    <= s_data.concept_id;
                    conf_reg   <= ONE_Q16;
                    n_reg      <= '0;
                    idx_reg    <= '0;
                    hit_reg    <= 1'b0;
                    out_reg    <= '{kind: KIND_END, node_id: '0, confidence: ONE_Q16,
                                    path_length: '0, status: 1'b0, last: 1'b1};
                    after_reg  <= ST_IDLE;
                end
                ST_CSCAN: begin
                    // one read issued per cycle until a hit or the table end, compared in the next cycle
                    if (!hit_reg && idx_reg < EC_W'(ccount_reg)) begin
                        idx_reg    <= idx_reg + 1'b1;
                        rvalid_reg <= 1'b1;
                    end
                    if (rvalid_reg && c_rdata == ckey) hit_reg <= 1'b1;
                end
                ST_CDONE: begin
                    idx_reg <= '0;
                    if (req_reg.opcode == OP_ADD_CONCEPT) begin
                        // new id with no free slot: dropped and flagged
                        out_reg <= '{kind: KIND_ACK, node_id: '0, confidence: '0,
                                     path_length: '0, status: !hit_reg && !c_we,
                                     last: 1'b1};
                        if (c_we) ccount_reg <= ccount_reg + 1'b1;
                    end else if (hit_reg) begin
                        // known node: record, emit, then scan its edges
                        visited_reg[n_reg[VD_W-1:0]] <= cur_reg;
                        n_reg     <= n_reg + 1'b1;
                        found_reg <= 1'b0;
                        out_reg   <= '{kind: KIND_NODE, node_id: cur_reg,
                                       confidence: conf_reg, path_length: n_reg + 1'b1,
                                       status: 1'b0, last: 1'b0};
                        after_reg <= ST_ESCAN;
                    end else begin
                        out_reg <= '{kind: KIND_END, node_id: '0, confidence: conf_reg,
                                     path_length: n_reg, status: 1'b0, last: 1'b1};
                        after_reg <= ST_IDLE;
                    end
                end
                ST_ESCAN: begin
                    if (idx_reg < ecount_reg) begin
                        idx_reg    <= idx_reg + 1'b1;
                        rvalid_reg <= 1'b1;
                    end
                    if (rvalid_reg && e_src == cur_reg && !dst_seen
                        && (!found_reg || e_w > best_w_reg)) begin
                        found_reg   <= 1'b1;
                        best_w_reg  <= e_w;
                        best_to_reg <= e_dst;
                    end
                end
                ST_EDONE: begin
                    prod_reg <= conf_reg * best_w_reg;
                    out_reg  <= '{kind: KIND_END, node_id: '0, confidence: conf_reg,
                                  path_length: n_reg, status: 1'b0, last: 1'b1};
                    after_reg <= ST_IDLE;
                end
                ST_MUL: begin
                    conf_reg <= prod_reg[WT_W+15:16];
                    cur_reg  <= best_to_reg;
                    idx_reg  <= '0;
                    hit_reg  <= 1'b0;
                    // depth reached: the end beat carries the new product
                    out_reg.confidence <= prod_reg[WT_W+15:16];
                end
                ST_EWR: begin
                    if (e_we) ecount_reg <= ecount_reg + 1'b1;
                    // full edge table: the edge is dropped and flagged
                    out_reg <= '{kind: KIND_ACK, node_id: '0, confidence: '0,
                                 path_length: '0, status: !e_we, last: 1'b1};
                end
                ST_ACK: begin
                    // the add acks are already set up, clear builds its own
                    if (req_reg.opcode == OP_CLEAR) begin
                        out_reg <= '{kind: KIND_ACK, node_id: '0, confidence: '0,
                                     path_length: '0, status: 1'b0, last: 1'b1};
                        ccount_reg <= '0;
                        ecount_reg <= '0;
                    end
                    after_reg <= ST_IDLE;
                end
                ST_EMIT: begin
                    if (m_ready && after_reg == ST_ESCAN) idx_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    `GWW_ASSERT_IMPL(a_in_only_idle, aclk, aresetn, s_ready, !m_valid,
        "input taken while a beat is pending")
    `GWW_ASSERT_IMPL(a_depth_bound, aclk, aresetn, m_valid, m_data.path_length <= DEPTH_MAX,
        "path length beyond depth limit")
    `GWW_ASSERT_IMPL(a_conf_bound, aclk, aresetn, m_valid, m_data.confidence <= ONE_Q16,
        "confidence above one")
    `GWW_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_data.last,
        s_ready, "last beat did not return to idle")
endmodule
